// ===== hw/rtl/fpf_pkg.sv =====
// ----------------------------------------------------------------------------
// fpf_pkg
// Shared types and constants of the frame packet fragmenter.
// ----------------------------------------------------------------------------
package fpf_pkg;

  // field widths
  localparam int unsigned TypeW     = 8;
  localparam int unsigned LenW      = 16;
  localparam int unsigned SizeW     = 10;
  localparam int unsigned ErrW      = 2;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 10;
  localparam int unsigned GrpDepth  = 4;
  localparam int unsigned GrpIdxW   = 2;

  // header layout
  localparam logic [SizeW-1:0] HdrBytes  = 10'd3;
  localparam logic [TypeW-1:0] MoreFlag  = 8'h80;

  // register reset values
  localparam logic [SizeW-1:0] MaxPktReset   = 10'd20;
  localparam logic [TypeW-1:0] ContTypeReset = 8'h00;

  // request codes
  localparam logic ReqStart = 1'b0;
  localparam logic ReqByte  = 1'b1;

  // error codes
  localparam logic [ErrW-1:0] ErrNone     = 2'd0;
  localparam logic [ErrW-1:0] ErrPktSize  = 2'd1;
  localparam logic [ErrW-1:0] ErrNoFrame  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxPkt   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegContType = 1'b1;

  // one word of the output stream
  typedef struct packed {
    logic [7:0]      out_byte;
    logic            packet_end;
    logic            frame_end;
    logic [ErrW-1:0] error_code;
  } res_t;

  // the words caused by one input item; last_idx is the count minus one
  typedef struct packed {
    res_t [GrpDepth-1:0] res;
    logic [GrpIdxW-1:0]  last_idx;
  } grp_t;

endpackage

// ===== hw/rtl/fpf_if.sv =====
// ----------------------------------------------------------------------------
// fpf_if
// Channel interfaces: input items, output stream words, register writes.
// ----------------------------------------------------------------------------
interface fpf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [fpf_pkg::TypeW-1:0]   frame_type;
  logic [fpf_pkg::LenW-1:0]    frame_length;
  logic [7:0]                  data_byte;

  modport source (output valid, req_type, frame_type, frame_length, data_byte,
                  input ready);
  modport sink (input valid, req_type, frame_type, frame_length, data_byte,
                output ready);
endinterface

interface fpf_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  out_byte;
  logic                        packet_end;
  logic                        frame_end;
  logic [fpf_pkg::ErrW-1:0]    error_code;

  modport source (output valid, out_byte, packet_end, frame_end, error_code,
                  input ready);
  modport sink (input valid, out_byte, packet_end, frame_end, error_code,
                output ready);
endinterface

interface fpf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fpf_pkg::CfgIdxW-1:0]   index;
  logic [fpf_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fpf_core.sv =====
// ----------------------------------------------------------------------------
// fpf_core
// Frame state, configuration registers and the per-item logic that builds
// the group of stream words caused by one input item into a group register.
// ----------------------------------------------------------------------------
module fpf_core import fpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpf_in_if.sink    in_i,
  fpf_cfg_if.sink   cfg_i,
  output logic      grp_valid_o,
  output grp_t      grp_o,
  input  logic      grp_ready_i
);

  // configuration registers
  logic [SizeW-1:0] max_pkt_q;
  logic [TypeW-1:0] cont_type_q;

  // frame state
  logic             active_q, active_d;
  logic [TypeW-1:0] held_type_q, held_type_d;
  logic [LenW-1:0]  total_len_q, total_len_d;
  logic [LenW-1:0]  bytes_done_q, bytes_done_d;
  logic [SizeW-1:0] chunk_left_q, chunk_left_d;

  // group register
  logic             grp_valid_q, grp_valid_d;
  grp_t             grp_q, grp_d;

  logic             in_acc;
  logic             too_small;
  logic [SizeW-1:0] cap_start;
  logic             fits;
  logic [LenW-1:0]  next_done;
  logic [SizeW-1:0] chunk_dec;
  logic [SizeW-1:0] cap_mid;
  logic [LenW-1:0]  remaining;
  logic             last_chunk;
  logic [SizeW-1:0] next_chunk;
  logic             frame_done;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q   <= MaxPktReset;
      cont_type_q <= ContTypeReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegMaxPkt:   max_pkt_q   <= cfg_i.data[SizeW-1:0];
        RegContType: cont_type_q <= cfg_i.data[TypeW-1:0];
        default:     ;
      endcase
    end
  end

  // handshake: take an item when the group register is free or draining
  assign in_i.ready  = !grp_valid_q || grp_ready_i;
  assign in_acc      = in_i.valid && in_i.ready;
  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

  // start item arithmetic
  assign too_small = (max_pkt_q <= HdrBytes);
  assign cap_start = max_pkt_q - HdrBytes;
  assign fits      = (in_i.frame_length <= {{(LenW-SizeW){1'b0}}, cap_start});

  // byte item arithmetic
  assign next_done  = bytes_done_q + {{(LenW-1){1'b0}}, 1'b1};
  assign chunk_dec  = (chunk_left_q != '0) ? chunk_left_q - {{(SizeW-1){1'b0}}, 1'b1}
                                           : chunk_left_q;
  assign frame_done = (next_done >= total_len_q);
  assign cap_mid    = too_small ? {{(SizeW-1){1'b0}}, 1'b1} : cap_start;
  assign remaining  = total_len_q - next_done;
  assign last_chunk = (remaining <= {{(LenW-SizeW){1'b0}}, cap_mid});
  assign next_chunk = last_chunk ? remaining[SizeW-1:0] : cap_mid;

  // next state and result group
  always_comb begin
    active_d     = active_q;
    held_type_d  = held_type_q;
    total_len_d  = total_len_q;
    bytes_done_d = bytes_done_q;
    chunk_left_d = chunk_left_q;
    grp_d        = '0;
    if (in_acc) begin
      unique case (in_i.req_type)
        ReqStart: begin
          if (too_small) begin
            active_d                 = 1'b0;
            grp_d.res[0].error_code  = ErrPktSize;
            grp_d.last_idx           = 2'd0;
          end else begin
            held_type_d    = in_i.frame_type;
            total_len_d    = in_i.frame_length;
            bytes_done_d   = '0;
            grp_d.last_idx = 2'd2;
            grp_d.res[1].out_byte = in_i.frame_length[15:8];
            grp_d.res[2].out_byte = in_i.frame_length[7:0];
            if (fits) begin
              chunk_left_d = in_i.frame_length[SizeW-1:0];
              active_d     = (in_i.frame_length != '0);
              grp_d.res[0].out_byte   = in_i.frame_type;
              grp_d.res[2].packet_end = (in_i.frame_length == '0);
              grp_d.res[2].frame_end  = (in_i.frame_length == '0);
            end else begin
              chunk_left_d = cap_start;
              active_d     = 1'b1;
              grp_d.res[0].out_byte = in_i.frame_type | MoreFlag;
            end
          end
        end
        ReqByte: begin
          if (!active_q) begin
            grp_d.res[0].error_code = ErrNoFrame;
            grp_d.last_idx          = 2'd0;
          end else begin
            bytes_done_d          = next_done;
            chunk_left_d          = chunk_dec;
            grp_d.res[0].out_byte = in_i.data_byte;
            if (frame_done) begin
              active_d                = 1'b0;
              chunk_left_d            = '0;
              grp_d.res[0].packet_end = 1'b1;
              grp_d.res[0].frame_end  = 1'b1;
              grp_d.last_idx          = 2'd0;
            end else if (chunk_dec == '0) begin
              // packet full: insert the next header behind this byte
              chunk_left_d            = next_chunk;
              grp_d.res[0].packet_end = 1'b1;
              grp_d.res[1].out_byte   = last_chunk ? held_type_q : cont_type_q;
              grp_d.res[2].out_byte   = {{(16-SizeW){1'b0}}, next_chunk[SizeW-1:8]};
              grp_d.res[3].out_byte   = next_chunk[7:0];
              grp_d.last_idx          = 2'd3;
            end else begin
              grp_d.last_idx = 2'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign grp_valid_d = in_acc || (grp_valid_q && !grp_ready_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      held_type_q  <= '0;
      total_len_q  <= '0;
      bytes_done_q <= '0;
      chunk_left_q <= '0;
      grp_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      held_type_q  <= held_type_d;
      total_len_q  <= total_len_d;
      bytes_done_q <= bytes_done_d;
      chunk_left_q <= chunk_left_d;
      grp_valid_q  <= grp_valid_d;
    end
  end

  // group payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      grp_q <= grp_d;
    end
  end

`ifndef SYNTH
  // a stalled group stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q && !grp_ready_i |=> grp_valid_q && $stable(grp_q))
    else $error("fpf_core: stalled group changed");

  // an open frame never has more bytes done than declared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> bytes_done_q < total_len_q)
    else $error("fpf_core: open frame past its length");
`endif

endmodule

// ===== hw/rtl/fpf_ser.sv =====
// ----------------------------------------------------------------------------
// fpf_ser
// Output stage: holds a result group, sends one word per cycle unless stalled.
// ----------------------------------------------------------------------------
module fpf_ser import fpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      grp_valid_i,
  input  grp_t      grp_i,
  output logic      grp_ready_o,
  fpf_out_if.source out_o
);

  logic               busy_q, busy_d;
  logic [GrpIdxW-1:0] idx_q, idx_d;
  grp_t               grp_q;
  logic               last_word;
  logic               out_acc;
  logic               load;
  res_t               cur;

  assign cur       = grp_q.res[idx_q];
  assign last_word = (idx_q == grp_q.last_idx);
  assign out_acc   = out_o.valid && out_o.ready;

  // free when empty or when the last word leaves this cycle
  assign grp_ready_o = !busy_q || (last_word && out_o.ready);
  assign load        = grp_valid_i && grp_ready_o;

  // word output
  assign out_o.valid      = busy_q;
  assign out_o.out_byte   = cur.out_byte;
  assign out_o.packet_end = cur.packet_end;
  assign out_o.frame_end  = cur.frame_end;
  assign out_o.error_code = cur.error_code;

  // word index and occupancy
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (grp_ready_o) begin
      busy_d = grp_valid_i;
      idx_d  = '0;
    end else if (out_acc) begin
      idx_d = idx_q + {{(GrpIdxW-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

`ifndef SYNTH
  // the word index stays within the held group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= grp_q.last_idx)
    else $error("fpf_ser: word index past group end");

  // a group starts at its first word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && idx_q == '0)
    else $error("fpf_ser: group not started at first word");
`endif

endmodule

// ===== hw/rtl/frame_packet_fragmenter.sv =====
// ----------------------------------------------------------------------------
// frame_packet_fragmenter
// Cuts typed frames into length-prefixed link packets as a byte stream.
// ----------------------------------------------------------------------------
// A start item opens a frame and yields its 3-byte first header; each byte
// item yields that byte and, when it fills a packet of a longer frame, the
// 3-byte header of the next packet right behind it. Items are taken one per
// cycle into a group register while the output stage sends the previous
// group and the output is not stalled, so items that yield a single word
// sustain one item per cycle, while a group with a header holds back later
// items until the output stage, sending one word per cycle, has sent it.
// Errors come out as a single word with error_code set. Register writes are
// always taken and are meant to happen while no words are pending.
module frame_packet_fragmenter import fpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpf_in_if.sink    in_i,
  fpf_cfg_if.sink   cfg_i,
  fpf_out_if.source out_o
);

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  // frame state and per-item logic
  fpf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp),
    .grp_ready_i (grp_ready)
  );

  // word-by-word output
  fpf_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .out_o       (out_o)
  );

endmodule

// ===== tb/frame_packet_fragmenter_test.sv =====
// ----------------------------------------------------------------------------
// frame_packet_fragmenter_test
// Self-checking testbench for the frame packet fragmenter. Frames, stray bytes
// and register writes are driven through the channel interfaces. A monitor
// predicts every output word from each accepted item. It checks the output
// stream word by word while both sides idle at random.
// ----------------------------------------------------------------------------
module frame_packet_fragmenter_test;
  import fpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxGap      = 17;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fpf_in_if  in_ch ();
  fpf_out_if out_ch ();
  fpf_cfg_if cfg_ch ();

  frame_packet_fragmenter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  // register copies and open-frame state of the predictor
  logic [SizeW-1:0] cfg_max_pkt   = MaxPktReset;
  logic [TypeW-1:0] cfg_cont_type = ContTypeReset;
  logic             fr_open       = 1'b0;
  logic [TypeW-1:0] fr_type       = '0;
  logic [LenW-1:0]  fr_total      = '0;
  logic [LenW-1:0]  fr_done       = '0;
  logic [SizeW-1:0] fr_chunk_left = '0;

  res_t pending_words[$];

  int unsigned src_gap_max   = MaxGap;
  int unsigned sink_gap_max  = MaxGap;
  int unsigned hold_cycles   = 0;
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned frames_begun  = 0;
  int unsigned frames_split  = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_count   = 0;

  // clock
  always #1ns clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run limit of %0d cycles reached, %0d words outstanding",
               $realtime, CycleLimit, pending_words.size());
      $display("[frame_packet_fragmenter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic void push_word(logic [7:0] b, logic pe, logic fe, logic [ErrW-1:0] err);
    res_t w;
    w.out_byte   = b;
    w.packet_end = pe;
    w.frame_end  = fe;
    w.error_code = err;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // type byte, then length big-endian; the last byte may close packet and frame
  function automatic void push_header(logic [7:0] htype, logic [15:0] hlen, logic ends);
    push_word(htype, 1'b0, 1'b0, ErrNone);
    push_word(hlen[15:8], 1'b0, 1'b0, ErrNone);
    push_word(hlen[7:0], ends, ends, ErrNone);
  endfunction

  function automatic void predict_packet_words(logic req, logic [7:0] ftype,
                                               logic [15:0] flen, logic [7:0] dbyte);
    logic [15:0] cap;
    logic [15:0] remaining;
    logic [15:0] n;
    if (req == ReqStart) begin
      // no room for a body: report and drop any open frame
      if (cfg_max_pkt <= HdrBytes) begin
        fr_open = 1'b0;
        push_word(8'h00, 1'b0, 1'b0, ErrPktSize);
        return;
      end
      cap      = 16'(cfg_max_pkt - HdrBytes);
      fr_type  = ftype;
      fr_total = flen;
      fr_done  = '0;
      frames_begun++;
      if (flen <= cap) begin
        fr_chunk_left = SizeW'(flen);
        fr_open       = (flen != 16'd0);
        push_header(ftype, flen, flen == 16'd0);
      end else begin
        fr_chunk_left = SizeW'(cap);
        fr_open       = 1'b1;
        frames_split++;
        push_header(ftype | MoreFlag, flen, 1'b0);
      end
      return;
    end

    // byte with nothing to belong to
    if (!fr_open) begin
      push_word(8'h00, 1'b0, 1'b0, ErrNoFrame);
      return;
    end

    fr_done = fr_done + 16'd1;
    if (fr_chunk_left != '0) fr_chunk_left = fr_chunk_left - 1'b1;

    // last byte of the frame
    if (fr_done >= fr_total) begin
      fr_open       = 1'b0;
      fr_chunk_left = '0;
      push_word(dbyte, 1'b1, 1'b1, ErrNone);
      return;
    end

    // packet full: next header follows, sized by the current register
    if (fr_chunk_left == '0) begin
      cap       = (cfg_max_pkt > HdrBytes) ? 16'(cfg_max_pkt - HdrBytes) : 16'd1;
      remaining = fr_total - fr_done;
      n         = (remaining < cap) ? remaining : cap;
      push_word(dbyte, 1'b1, 1'b0, ErrNone);
      fr_chunk_left = SizeW'(n);
      push_header((remaining <= cap) ? fr_type : cfg_cont_type, n, 1'b0);
    end else begin
      push_word(dbyte, 1'b0, 1'b0, ErrNone);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: registers, accepted items and output words, in that order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : stream_checker
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          RegMaxPkt:   cfg_max_pkt   = cfg_ch.data[SizeW-1:0];
          RegContType: cfg_cont_type = cfg_ch.data[TypeW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_packet_words(in_ch.req_type, in_ch.frame_type, in_ch.frame_length,
                             in_ch.data_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte   = out_ch.out_byte;
        got.packet_end = out_ch.packet_end;
        got.frame_end  = out_ch.frame_end;
        got.error_code = out_ch.error_code;
        if (pending_words.size() == 0) begin
          $display("%0t: extra word: expected none, got byte %02h pe %b fe %b err %0d",
                   $realtime, got.out_byte, got.packet_end, got.frame_end, got.error_code);
          fail_count++;
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            $write("%0t: word %0d mismatch: expected byte %02h pe %b fe %b err %0d, ",
                   $realtime, words_checked, want.out_byte, want.packet_end,
                   want.frame_end, want.error_code);
            $display("got byte %02h pe %b fe %b err %0d",
                     got.out_byte, got.packet_end, got.frame_end, got.error_code);
            fail_count++;
          end
          words_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output side: random stalls per word, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin : stream_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = $urandom_range(0, sink_gap_max);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_item(logic req, logic [7:0] ftype, logic [15:0] flen, logic [7:0] dbyte);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.frame_type   <= ftype;
    in_ch.frame_length <= flen;
    in_ch.data_byte    <= dbyte;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // start item followed by nbytes random payload bytes
  task automatic send_frame(logic [7:0] ftype, logic [15:0] flen, int unsigned nbytes);
    send_item(ReqStart, ftype, flen, 8'($urandom));
    repeat (nbytes) send_item(ReqByte, 8'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [CfgDataW-1:0] max_pkt, logic [CfgDataW-1:0] cont);
    wait_drained();
    write_reg(RegMaxPkt, max_pkt);
    write_reg(RegContType, cont);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    src_gap_max  = MaxGap;
    sink_gap_max = MaxGap;
    // stray byte before any frame
    send_item(ReqByte, 8'hFF, 16'hFFFF, 8'hA5);
    // empty frame closes within its header
    send_item(ReqStart, 8'hFF, 16'h0000, 8'h00);
    // single-packet frame with extreme bytes, then one byte past its length
    send_item(ReqStart, 8'h00, 16'd2, 8'hFF);
    send_item(ReqByte, 8'h00, 16'h0000, 8'h00);
    send_item(ReqByte, 8'hFF, 16'hFFFF, 8'hFF);
    send_item(ReqByte, 8'h00, 16'h0000, 8'h3C);
    // one-byte bodies: every byte closes a packet
    set_config(10'd4, 10'h3FF);
    send_frame(8'h5A, 16'd3, 3);
    // longest length, abandoned by a new start
    send_frame(8'h7F, 16'hFFFF, 1);
    send_frame(8'h81, 16'd1, 1);
    // packet size 517: exact fit, then one byte over
    set_config(10'd517, 10'h100);
    send_item(ReqStart, 8'h12, 16'd514, 8'h00);
    send_item(ReqStart, 8'h34, 16'd515, 8'h00);
    // packet size shrinks to the header size in the middle of a frame
    set_config(10'd8, 10'h077);
    send_frame(8'h33, 16'd12, 4);
    wait_drained();
    write_reg(RegMaxPkt, 10'd3);
    repeat (3) send_item(ReqByte, 8'($urandom), 16'($urandom), 8'($urandom));
    // start with no room for a body drops the open frame
    send_item(ReqStart, 8'h44, 16'd5, 8'h00);
    send_item(ReqByte, 8'h00, 16'h0000, 8'h99);
    // zero packet size
    wait_drained();
    write_reg(RegMaxPkt, 10'd0);
    send_item(ReqStart, 8'hAA, 16'hAAAA, 8'h55);
  endtask

  // mostly complete frames, some noise, truncated and overlong frames
  task automatic test_random_traffic(int unsigned n_items, int unsigned gap_max);
    int unsigned first;
    int unsigned cfg_mark;
    int unsigned kind;
    int unsigned flen;
    logic [CfgDataW-1:0] size;
    src_gap_max  = gap_max;
    sink_gap_max = gap_max;
    first        = items_sent;
    cfg_mark     = items_sent;
    while (items_sent - first < n_items) begin
      if (items_sent == first || items_sent - cfg_mark >= 60) begin
        kind = $urandom_range(0, 9);
        case (kind)
          0:       size = CfgDataW'($urandom_range(0, 3));
          1:       size = 10'd517;
          2:       size = 10'd4;
          default: size = CfgDataW'($urandom_range(5, 45));
        endcase
        set_config(size, CfgDataW'($urandom_range(0, 1023)));
        cfg_mark = items_sent;
      end
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        send_item(ReqByte, 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (kind == 1) begin
        send_frame(8'($urandom), 16'($urandom), $urandom_range(0, 4));
      end else if (kind == 2) begin
        flen = $urandom_range(0, 6);
        send_frame(8'($urandom), 16'(flen), flen + $urandom_range(1, 2));
      end else begin
        flen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
        send_frame(8'($urandom), 16'(flen), flen);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering header-heavy bytes
  task automatic test_output_hold();
    set_config(10'd4, 10'h0AA);
    src_gap_max  = 0;
    sink_gap_max = 3;
    hold_cycles  = 150;
    send_frame(8'hC3, 16'd40, 40);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin : main_sequence
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= ReqStart;
    in_ch.frame_type   <= '0;
    in_ch.frame_length <= '0;
    in_ch.data_byte    <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= RegMaxPkt;
    cfg_ch.data        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(150, MaxGap);
    test_random_traffic(70, 0);
    test_output_hold();
    test_random_traffic(140, MaxGap);
    wait_drained();

    $display("covered %0d items: %0d frames begun, %0d split, %0d stream words checked",
             items_sent, frames_begun, frames_split, words_checked);
    $display("%0d register writes, packet sizes from 0 to 517, a long output hold",
             reg_writes);
    if (fail_count == 0) begin
      $display("[frame_packet_fragmenter] OK");
    end else begin
      $display("[frame_packet_fragmenter] ERROR");
    end
    $finish;
  end

endmodule
